// ===== hdl/fcw_pkg.sv =====
// Shared types, constants and helpers for the FAT12 cluster chain walker.
`default_nettype none
package fcw_pkg;

  localparam int TABLE_BYTES = 8192;
  localparam int MAX_RUN     = 64;

  localparam int TBL_AW  = $clog2(TABLE_BYTES);
  localparam int RUN_W   = $clog2(MAX_RUN + 1);
  localparam int POS_W   = 14;
  localparam int QDEPTH  = 2;
  localparam int QAW     = $clog2(QDEPTH);
  localparam int QCW     = $clog2(QDEPTH + 1);

  localparam logic [11:0] ENTRY_MASK = 12'h0FFF;
  localparam logic [11:0] FIRST_DATA = 12'h002;

  typedef enum logic [1:0] {
    REG_DATA_START = 2'd0,
    REG_SPC        = 2'd1,
    REG_TOTAL      = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_WALK  = 2'd1,
    CMD_EMPTY = 2'd2
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_LO   = 2'd1,
    BK_HI   = 2'd2,
    BK_OUT  = 2'd3
  } bk_state_t;

  typedef struct packed {
    logic        action;
    logic [12:0] table_byte_index;
    logic [7:0]  table_byte_value;
    logic [11:0] start_cluster;
  } in_item_t;

  typedef struct packed {
    logic [19:0] sector_address;
    logic [11:0] cluster_number;
    logic [11:0] following_cluster;
    logic        last_of_run;
    logic        chain_empty;
    logic        run_truncated;
  } out_item_t;

  typedef struct packed {
    logic [15:0] data_start_sector;
    logic [7:0]  cluster_size;
    logic [11:0] data_cluster_total;
  } cfg_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [12:0] addr;
    logic [7:0]  data;
    logic [11:0] cluster;
  } cmd_t;

  function automatic logic cluster_ok(input logic [11:0] c, input logic [11:0] total);
    logic [11:0] d;
    d = c - FIRST_DATA;
    return (c >= FIRST_DATA) && (d < total);
  endfunction

  function automatic logic [POS_W-1:0] byte_pos(input logic [11:0] c);
    return {2'b00, c} + {3'b000, c[11:1]};
  endfunction

  function automatic logic pos_ok(input logic [POS_W-1:0] p);
    return p < POS_W'(TABLE_BYTES);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/fcw_front.sv =====
// Front stage: accepts input beats and classifies them into table writes, walks and empty walks.
`default_nettype none
module fcw_front import fcw_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  input  wire cfg_t     cfg,
  output logic          cmd_valid,
  input  wire logic     cmd_ready,
  output cmd_t          cmd_data
);

  logic f_valid_r, f_valid_nxt;
  cmd_t f_cmd_r, f_cmd_nxt;
  logic keep;

  assign in_ready  = !f_valid_r || cmd_ready;
  assign cmd_valid = f_valid_r;
  assign cmd_data  = f_cmd_r;

  always_comb begin
    f_cmd_nxt.addr    = in_data.table_byte_index;
    f_cmd_nxt.data    = in_data.table_byte_value;
    f_cmd_nxt.cluster = in_data.start_cluster;
    if (!in_data.action) begin
      f_cmd_nxt.kind = CMD_WRITE;
      keep = {1'b0, in_data.table_byte_index} < 14'(TABLE_BYTES);
    end else begin
      f_cmd_nxt.kind = cluster_ok(in_data.start_cluster, cfg.data_cluster_total)
                       ? CMD_WALK : CMD_EMPTY;
      keep = 1'b1;
    end
  end

  always_comb begin
    f_valid_nxt = f_valid_r;
    if (in_ready) begin
      f_valid_nxt = in_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      f_cmd_r <= f_cmd_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/fcw_queue.sv =====
// Short command queue between the front and back stages.
`default_nettype none
module fcw_queue import fcw_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire cmd_t push_data,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output cmd_t      pop_data
);

  cmd_t           slot_r [QDEPTH];
  logic [QAW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign push_ready = cnt_r != QCW'(QDEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = slot_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wptr_nxt = do_push ? QAW'((32'(wptr_r) + 1) % QDEPTH) : wptr_r;
    rptr_nxt = do_pop  ? QAW'((32'(rptr_r) + 1) % QDEPTH) : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/fcw_back.sv =====
// Back stage: holds the allocation table, follows chains and drives the result register.
`default_nettype none
module fcw_back import fcw_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cfg_t cfg,
  input  wire logic cmd_valid,
  output logic      cmd_ready,
  input  wire cmd_t cmd_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_item_t out_data
);

  logic [7:0] tbl_mem [TABLE_BYTES];

  bk_state_t      state_r, state_nxt;
  logic [11:0]    c_r, c_nxt;
  logic [RUN_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]     lo_r;
  logic [11:0]    entry_r;
  logic [19:0]    prod_r;
  logic [7:0]     rdata_r;
  logic           rd_ok_r;
  logic           out_valid_r, out_valid_nxt;
  out_item_t      out_r, out_nxt;
  logic           load_out;

  logic           out_free, more, capped, mem_we;
  logic [7:0]     rbyte;
  logic [15:0]    pair;
  logic [11:0]    entry_nxt;
  logic [11:0]    diff;
  logic [POS_W-1:0] rd_pos;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign rbyte     = rd_ok_r ? rdata_r : 8'h00;
  assign pair      = {rbyte, lo_r};
  assign entry_nxt = c_r[0] ? pair[15:4] : (pair[11:0] & ENTRY_MASK);
  assign more      = cluster_ok(entry_r, cfg.data_cluster_total);
  assign capped    = more && (cnt_r == RUN_W'(MAX_RUN - 1));
  assign diff      = c_r - FIRST_DATA;

  assign cmd_ready = (state_r == BK_IDLE) && (cmd_data.kind != CMD_EMPTY || out_free);
  assign mem_we    = (state_r == BK_IDLE) && cmd_valid && cmd_data.kind == CMD_WRITE;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (cmd_valid && cmd_data.kind == CMD_WALK) begin
          state_nxt = BK_LO;
        end
      end
      BK_LO:  state_nxt = BK_HI;
      BK_HI:  state_nxt = BK_OUT;
      BK_OUT: begin
        if (out_free) begin
          state_nxt = (more && !capped) ? BK_LO : BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    c_nxt         = c_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    load_out      = 1'b0;
    rd_pos        = byte_pos(c_r);
    case (state_r)
      BK_IDLE: begin
        rd_pos = byte_pos(cmd_data.cluster);
        if (cmd_valid && cmd_data.kind == CMD_WALK) begin
          c_nxt   = cmd_data.cluster;
          cnt_nxt = '0;
        end else if (cmd_valid && cmd_data.kind == CMD_EMPTY && out_free) begin
          load_out                  = 1'b1;
          out_valid_nxt             = 1'b1;
          out_nxt.sector_address    = '0;
          out_nxt.cluster_number    = cmd_data.cluster;
          out_nxt.following_cluster = '0;
          out_nxt.last_of_run       = 1'b1;
          out_nxt.chain_empty       = 1'b1;
          out_nxt.run_truncated     = 1'b0;
        end
      end
      BK_LO: begin
        rd_pos = byte_pos(c_r) + POS_W'(1);
      end
      BK_HI: begin
        rd_pos = byte_pos(c_r);
      end
      BK_OUT: begin
        rd_pos = byte_pos(entry_r);
        if (out_free) begin
          load_out                  = 1'b1;
          out_valid_nxt             = 1'b1;
          out_nxt.sector_address    = {4'h0, cfg.data_start_sector} + prod_r;
          out_nxt.cluster_number    = c_r;
          out_nxt.following_cluster = entry_r;
          out_nxt.last_of_run       = !more || capped;
          out_nxt.chain_empty       = 1'b0;
          out_nxt.run_truncated     = capped;
          if (more && !capped) begin
            c_nxt   = entry_r;
            cnt_nxt = cnt_r + RUN_W'(1);
          end
        end
      end
      default: begin
        rd_pos = byte_pos(c_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r <= c_nxt;
    if (load_out) begin
      out_r <= out_nxt;
    end
    if (state_r == BK_LO) begin
      lo_r   <= rbyte;
      prod_r <= {8'h00, diff} * {12'h000, cfg.cluster_size};
    end
    if (state_r == BK_HI) begin
      entry_r <= entry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem[cmd_data.addr[TBL_AW-1:0]] <= cmd_data.data;
    end
    rdata_r <= tbl_mem[rd_pos[TBL_AW-1:0]];
    rd_ok_r <= pos_ok(rd_pos);
  end

endmodule
`default_nettype wire

// ===== hdl/fat12_cluster_chain_walker.sv =====
// Top level of the FAT12 cluster chain walker: configuration registers and stage wiring.
`default_nettype none
// A table-byte write beat (action 0) is taken and gives no result; a write beyond
// the table is dropped. A walk beat (action 1) gives one result per cluster of the
// chain, up to 64: each link needs two byte reads from the table memory's single
// read port and then a step to register the result. A walk whose start cluster
// is out of range gives one result flagged chain_empty. A run stopped at the cap
// is flagged run_truncated and its following_cluster is where the chain would
// continue. Beats pass through a front register and a two-entry queue, so up to
// three beats are taken while a walk runs and while a result waits at the output.
// The table is not cleared by reset: read only entries that have been written.
// Write configuration only while the block is idle.
module fat12_cluster_chain_walker import fcw_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  cfg_t cfg_r, cfg_nxt;

  logic f_valid, f_ready;
  cmd_t f_cmd;
  logic q_valid, q_ready;
  cmd_t q_cmd;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DATA_START: cfg_nxt.data_start_sector   = cfg_wdata;
        REG_SPC:        cfg_nxt.cluster_size        = cfg_wdata[7:0];
        REG_TOTAL:      cfg_nxt.data_cluster_total  = cfg_wdata[11:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.data_start_sector   <= 16'd0;
      cfg_r.cluster_size        <= 8'd1;
      cfg_r.data_cluster_total  <= 12'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  fcw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd_data  (f_cmd)
  );

  fcw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cmd)
  );

  fcw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd_data  (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.chain_empty |-> out_data.last_of_run && !out_data.run_truncated)
    else $error("empty chain result not final");

  a_trunc_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.run_truncated |-> out_data.last_of_run)
    else $error("truncated result not final");

  a_trunc_link_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.run_truncated
      |-> cluster_ok(out_data.following_cluster, cfg_r.data_cluster_total))
    else $error("truncated run without a continuing link");

  a_mid_link_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_of_run ##1 out_valid
      |-> out_data.cluster_number == $past(out_data.following_cluster))
    else $error("chain link broken between results");

endmodule
`default_nettype wire
